@@ rtl/fct_pkg.sv @@
package fct_pkg;

  localparam int QUEUE_COUNT_DEF   = 3;
  localparam int PENDING_DEPTH_DEF = 8;
  localparam int QUEUE_MAX         = 3;
  localparam int TIME_W            = 64;
  localparam int IN_W              = (2 * QUEUE_MAX + 1) * TIME_W;
  localparam int OUT_W             = ((2 * TIME_W + 1 + 7) / 8) * 8;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_WAIT  = 1'b1;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic ready;
    logic match;
  } cell_status_t;

endpackage

@@ rtl/fct_cell.sv @@
module fct_cell import fct_pkg::*; #(
  parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
) (
  input  logic                                clk,
  input  cell_ctrl_t                          ctrl,
  input  logic [TIME_W-1:0]                   nbr_tick,
  input  logic [QUEUE_COUNT-1:0][TIME_W-1:0]  nbr_stamps,
  input  logic [TIME_W-1:0]                   ld_tick,
  input  logic [QUEUE_COUNT-1:0][TIME_W-1:0]  ld_stamps,
  input  logic [QUEUE_COUNT-1:0][TIME_W-1:0]  done_time,
  input  logic [TIME_W-1:0]                   wait_tick,
  output logic [TIME_W-1:0]                   tick,
  output logic [QUEUE_COUNT-1:0][TIME_W-1:0]  stamps,
  output cell_status_t                        status
);

  logic ready;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      tick   <= ld_tick;
      stamps <= ld_stamps;
    end else if (ctrl.shift) begin
      tick   <= nbr_tick;
      stamps <= nbr_stamps;
    end
  end

  always_comb begin
    ready = 1'b1;
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      if (stamps[q] > done_time[q]) ready = 1'b0;
    end
  end

  assign status.ready = ready;
  assign status.match = (tick == wait_tick);

endmodule

@@ rtl/frame_completion_tracker.sv @@
// Frame completion tracker. Each input transfer is a start-tick item (tuser 0) or a wait item
// (tuser 1) and yields one result transfer with the completed tick, the current tick and an
// error flag. Pending ticks sit in a chain of cells, oldest at the head, and leave the chain
// by shifting it one cell per cycle. A start item retires the ready head entries (POP), then
// pushes its tick if not yet complete (PUSH); a wait item is checked (WCHK) and may shift
// the chain until its tick leaves (WPOP). Both then wait in OUT while an earlier result is
// still held by the sink. The next item can be taken in the cycle in which the result is
// presented. The block holds one item at a time; the retire shift of the chain sets the pace.
module frame_completion_tracker import fct_pkg::*; #(
  parameter int QUEUE_COUNT   = QUEUE_COUNT_DEF,
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // submitted_time_0, submitted_time_1, submitted_time_2, done_time_0, done_time_1,
  // done_time_2, wait_tick
  input  logic [IN_W-1:0]  s_tdata,
  // action
  input  logic [0:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // completed_tick, current_tick, error, zero fill
  output logic [OUT_W-1:0] m_tdata
);

  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_POP  = 3'd1;
  localparam logic [2:0] ST_PUSH = 3'd2;
  localparam logic [2:0] ST_WCHK = 3'd3;
  localparam logic [2:0] ST_WPOP = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]                          state;
  logic [QUEUE_COUNT-1:0][TIME_W-1:0]  sub;
  logic [QUEUE_COUNT-1:0][TIME_W-1:0]  done;
  logic [TIME_W-1:0]                   wt;
  logic [CNT_W-1:0]                    count;
  logic [TIME_W-1:0]                   completed;
  logic [TIME_W-1:0]                   current;
  logic                                err;

  logic [TIME_W-1:0]                   cell_tick   [PENDING_DEPTH];
  logic [QUEUE_COUNT-1:0][TIME_W-1:0]  cell_stamps [PENDING_DEPTH];
  cell_status_t                        cell_status [PENDING_DEPTH];
  cell_ctrl_t                          cell_ctrl   [PENDING_DEPTH];

  logic sub_done;
  logic found;
  logic full;
  logic shift;
  logic push;

  assign s_tready = (state == ST_IDLE);
  assign full     = (count == CNT_W'(PENDING_DEPTH));

  always_comb begin
    sub_done = 1'b1;
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      if (sub[q] > done[q]) sub_done = 1'b0;
    end
  end

  always_comb begin
    found = 1'b0;
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      if ((CNT_W'(i) < count) && cell_status[i].match) found = 1'b1;
    end
  end

  always_comb begin
    shift = 1'b0;
    push  = 1'b0;
    unique case (state)
      ST_POP:  shift = (count != '0) && cell_status[0].ready;
      ST_PUSH: begin
        push  = !sub_done;
        shift = !sub_done && full;
      end
      ST_WPOP: shift = 1'b1;
      default: ;
    endcase
  end

  for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_cell
    logic [TIME_W-1:0]                  nbr_tick;
    logic [QUEUE_COUNT-1:0][TIME_W-1:0] nbr_stamps;

    if (i == PENDING_DEPTH - 1) begin : g_tail
      assign nbr_tick   = cell_tick[i];
      assign nbr_stamps = cell_stamps[i];
    end else begin : g_body
      assign nbr_tick   = cell_tick[i+1];
      assign nbr_stamps = cell_stamps[i+1];
    end

    assign cell_ctrl[i].shift = shift;
    assign cell_ctrl[i].load  = push && (full ? (i == PENDING_DEPTH - 1)
                                              : (count == CNT_W'(i)));

    fct_cell #(
      .QUEUE_COUNT (QUEUE_COUNT)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .nbr_tick   (nbr_tick),
      .nbr_stamps (nbr_stamps),
      .ld_tick    (current),
      .ld_stamps  (sub),
      .done_time  (done),
      .wait_tick  (wt),
      .tick       (cell_tick[i]),
      .stamps     (cell_stamps[i]),
      .status     (cell_status[i])
    );
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      for (int q = 0; q < QUEUE_COUNT; q++) begin
        sub[q]  <= s_tdata[q*TIME_W +: TIME_W];
        done[q] <= s_tdata[(QUEUE_MAX+q)*TIME_W +: TIME_W];
      end
      wt <= s_tdata[2*QUEUE_MAX*TIME_W +: TIME_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      completed <= '0;
      current   <= '0;
      err       <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            err   <= 1'b0;
            state <= (s_tuser[0] == ACT_WAIT) ? ST_WCHK : ST_POP;
          end
        end
        ST_POP: begin
          if (shift) begin
            completed <= cell_tick[0];
            count     <= count - 1'b1;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (sub_done) begin
            completed <= current;
          end else if (full) begin
            err <= 1'b1;
          end else begin
            count <= count + 1'b1;
          end
          current <= current + 1'b1;
          state   <= ST_OUT;
        end
        ST_WCHK: begin
          if (wt <= completed) begin
            state <= ST_OUT;
          end else if (wt >= current || !found) begin
            err   <= 1'b1;
            state <= ST_OUT;
          end else begin
            state <= ST_WPOP;
          end
        end
        ST_WPOP: begin
          count <= count - 1'b1;
          if (cell_status[0].match) begin
            completed <= wt;
            state     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {(OUT_W - 2 * TIME_W - 1)'(0), err, current, completed};
    end
  end

endmodule

@@ rtl/fct_checker.sv @@
module fct_checker import fct_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // one item in flight: no second transfer right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // a result never shows in the cycle right after its item transfer
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !(m_tvalid && !m_tready) |=> !m_tvalid)
    else $error("result presented too early");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind frame_completion_tracker fct_checker u_fct_checker (.*);

@@ tb/sv/frame_completion_tracker_tb.sv @@
`timescale 1ns / 100ps

module frame_completion_tracker_tb;
  import fct_pkg::*;

  localparam int DEPTH        = PENDING_DEPTH_DEF;
  localparam int QUEUES       = QUEUE_COUNT_DEF;
  localparam int STALL_LIMIT  = 400;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_ITEMS = 900;
  localparam int CALM_ITEMS   = 150;

  typedef logic [QUEUE_MAX-1:0][TIME_W-1:0] qtimes_t;

  typedef struct {
    logic [TIME_W-1:0] completed;
    logic [TIME_W-1:0] current;
    logic              err;
  } tick_status_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic [0:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  // tracker copy kept in step with the accepted transfers
  logic [TIME_W-1:0] pend_tick [DEPTH];
  qtimes_t           pend_times [DEPTH];
  int                pend_cnt = 0;
  logic [TIME_W-1:0] done_tick = '0;
  logic [TIME_W-1:0] cur_tick = '0;

  tick_status_t status_q[$];
  tick_status_t want;
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           stall_left = 0;
  bit           gaps_on = 1'b1;
  bit           stalls_on = 1'b1;

  frame_completion_tracker uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic qtimes_t times3(logic [TIME_W-1:0] q0, logic [TIME_W-1:0] q1,
                                     logic [TIME_W-1:0] q2);
    qtimes_t r;
    r[0] = q0;
    r[1] = q1;
    r[2] = q2;
    return r;
  endfunction

  function automatic bit times_done(qtimes_t t, qtimes_t d);
    for (int q = 0; q < QUEUES; q++) begin
      if (t[q] > d[q]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void retire_oldest(int n);
    int rest;
    if (n > pend_cnt) n = pend_cnt;
    rest = pend_cnt - n;
    for (int i = 0; i < rest; i++) begin
      pend_tick[i] = pend_tick[i + n];
      pend_times[i] = pend_times[i + n];
    end
    pend_cnt = rest;
  endfunction

  function automatic tick_status_t track_tick(logic act, qtimes_t sub, qtimes_t done,
                                              logic [TIME_W-1:0] wtick);
    tick_status_t r;
    int pops;
    int hit;
    r.err = 1'b0;
    if (act == ACT_START) begin
      pops = 0;
      while (pops < pend_cnt && times_done(pend_times[pops], done)) begin
        done_tick = pend_tick[pops];
        pops++;
      end
      retire_oldest(pops);
      if (!times_done(sub, done)) begin
        if (pend_cnt >= DEPTH) begin
          retire_oldest(1);
          r.err = 1'b1;
        end
        pend_tick[pend_cnt] = cur_tick;
        pend_times[pend_cnt] = sub;
        pend_cnt++;
      end else begin
        done_tick = cur_tick;
      end
      cur_tick = cur_tick + 1'b1;
    end else if (wtick > done_tick) begin
      if (wtick >= cur_tick) begin
        r.err = 1'b1;
      end else begin
        hit = -1;
        for (int i = 0; i < pend_cnt; i++) begin
          if (hit < 0 && pend_tick[i] == wtick) hit = i;
        end
        if (hit >= 0) begin
          retire_oldest(hit + 1);
          done_tick = wtick;
        end else begin
          r.err = 1'b1;
        end
      end
    end
    r.completed = done_tick;
    r.current = cur_tick;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // called at a falling edge, returns at a falling edge with tvalid low
  task automatic send_item(logic act, qtimes_t sub, qtimes_t done, logic [TIME_W-1:0] wtick);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = act;
    s_tdata = {wtick, done, sub};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    status_q.push_back(track_tick(act, sub, done, wtick));
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      m_tready = 1'b0;
      stall_left = $urandom_range(1, 17) - 1;
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (status_q.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = status_q.pop_front();
        if (m_tdata[63:0] !== want.completed)
          report_mismatch($sformatf("completed_tick %0h, expected %0h",
                                    m_tdata[63:0], want.completed));
        if (m_tdata[127:64] !== want.current)
          report_mismatch($sformatf("current_tick %0h, expected %0h",
                                    m_tdata[127:64], want.current));
        if (m_tdata[128] !== want.err)
          report_mismatch($sformatf("error %b, expected %b", m_tdata[128], want.err));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic test_start_ticks();
    qtimes_t zero;
    qtimes_t ones;
    zero = times3(0, 0, 0);
    ones = times3('1, '1, '1);
    send_item(ACT_START, zero, zero, '0);
    send_item(ACT_START, times3(5, 6, 7), zero, rand64());
    send_item(ACT_START, times3(0, 0, 9), zero, rand64());
    // retires the first entry only, queue 2 holds the second back
    send_item(ACT_START, times3(12, 12, 12), times3(5, 6, 7), rand64());
    send_item(ACT_START, ones, ones, '1);
    send_item(ACT_START, times3(1, 0, 0), times3(0, '1, '1), rand64());
    // newer tick completes at once while an older one stays pending
    send_item(ACT_START, zero, zero, rand64());
  endtask

  task automatic test_waits();
    qtimes_t zero;
    zero = times3(0, 0, 0);
    send_item(ACT_WAIT, zero, zero, pend_tick[0]);
    send_item(ACT_WAIT, zero, zero, cur_tick);
    send_item(ACT_WAIT, zero, zero, '1);
    send_item(ACT_WAIT, zero, zero, '0);
    repeat (3) send_item(ACT_START, times3(50, 50, 50), zero, rand64());
    send_item(ACT_WAIT, zero, zero, pend_tick[2]);
  endtask

  task automatic test_overflow();
    qtimes_t zero;
    zero = times3(0, 0, 0);
    repeat (DEPTH + 1) send_item(ACT_START, times3(100, 100, 100), zero, rand64());
    // ticks are contiguous, so the one just before the head was dropped
    send_item(ACT_WAIT, zero, zero, pend_tick[0] - 1'b1);
    send_item(ACT_WAIT, zero, zero, pend_tick[2]);
    send_item(ACT_START, times3(100, 100, 100), times3(100, 100, 100), rand64());
  endtask

  task automatic test_random();
    qtimes_t           tl_sub;
    qtimes_t           tl_done;
    qtimes_t           sub;
    qtimes_t           done;
    logic [TIME_W-1:0] wtick;
    logic [TIME_W-1:0] lag;
    logic              act;
    bit                frozen;
    int                sel;
    int                pick;
    frozen = 1'b0;
    for (int q = 0; q < QUEUE_MAX; q++) begin
      tl_sub[q] = rand64() >> 1;
      tl_done[q] = tl_sub[q];
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      if (n % 40 == 0) frozen = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      wtick = rand64();
      sub = tl_sub;
      done = tl_done;
      if (sel < 8) begin
        act = 1'($urandom_range(0, 1));
        sub = {rand64(), rand64(), rand64()};
        done = {rand64(), rand64(), rand64()};
      end else if (sel < 33) begin
        act = ACT_WAIT;
        pick = $urandom_range(0, 9);
        if (pick <= 5 && pend_cnt > 0) wtick = pend_tick[$urandom_range(0, pend_cnt - 1)];
        else if (pick == 6) wtick = done_tick - $urandom_range(0, 2);
        else if (pick == 7) wtick = cur_tick + $urandom_range(0, 2);
        else if (pick == 8) wtick = cur_tick - $urandom_range(1, 12);
      end else begin
        act = ACT_START;
        for (int q = 0; q < QUEUE_MAX; q++) begin
          tl_sub[q] = tl_sub[q] + $urandom_range(0, 3);
          lag = tl_sub[q] - tl_done[q];
          if (frozen || $urandom_range(0, 2) == 0) begin
            // this queue makes no progress
          end else if ($urandom_range(0, 4) == 0) begin
            tl_done[q] = tl_sub[q];
          end else begin
            tl_done[q] = tl_done[q] + ((lag > 3) ? $urandom_range(0, 3) : lag);
          end
        end
        sub = tl_sub;
        done = tl_done;
      end
      send_item(act, sub, done, wtick);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_start_ticks();
    test_waits();
    test_overflow();
    test_random();
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
